FILE: rtl/core/wsmsa_pkg.sv
package wsmsa_pkg;

	// Field widths of the request and result.
	localparam int SPEED_W  = 16;
	localparam int FACTOR_W = 16;
	localparam int STEER_W  = 24;
	localparam int FWA_W    = 19;

	// Reset value of the speed scale register (1.0 in Q2.14).
	localparam logic [FACTOR_W-1:0] SPEED_FACTOR_RESET = 16'd16384;

	// Steering map: segment count and fixed-point widths.
	localparam int NUM_SEGMENTS = 12;
	localparam int SEG_IDX_W    = $clog2(NUM_SEGMENTS);
	localparam int RECIP_W      = 21;
	localparam int RECIP_SHIFT  = 24;

	typedef logic signed [SPEED_W-1:0] speed_t;
	typedef logic signed [STEER_W-1:0] steer_t;
	typedef logic signed [FWA_W-1:0]   fwa_t;
	typedef logic [FACTOR_W-1:0]       factor_t;

	// Result of the longitudinal speed path.
	typedef struct packed {
		speed_t value;
		logic   saturated;
	} speed_res_t;

	// Upper break point of each segment, in 2^-16 rad.
	localparam logic [STEER_W-1:0] SEG_LIMIT [NUM_SEGMENTS] = '{
		24'd27652, 24'd49224, 24'd74932, 24'd91452, 24'd118930, 24'd240614,
		24'd355871, 24'd489888, 24'd631788, 24'd774079, 24'd885745, 24'd6553600
	};

	// Lower break point of each segment.
	localparam logic [STEER_W-1:0] SEG_START [NUM_SEGMENTS] = '{
		24'd0, 24'd27652, 24'd49224, 24'd74932, 24'd91452, 24'd118930,
		24'd240614, 24'd355871, 24'd489888, 24'd631788, 24'd774079, 24'd885745
	};

	// Wheel angle at the start of each segment.
	localparam logic [FWA_W-1:0] SEG_OFFSET [NUM_SEGMENTS] = '{
		19'd0, 19'd1144, 19'd2288, 19'd3431, 19'd4575, 19'd5719,
		19'd11438, 19'd17157, 19'd22876, 19'd28595, 19'd34315, 19'd37746
	};

	// Slope of each segment as a reciprocal scaled by 2^24.
	localparam logic [RECIP_W-1:0] SEG_RECIP [NUM_SEGMENTS] = '{
		21'd693990, 21'd889566, 21'd746483, 21'd1161576, 21'd698381, 21'd788525,
		21'd832492, 21'd715956, 21'd676182, 21'd674325, 21'd515561, 21'd455748
	};

endpackage

FILE: rtl/core/wsmsa_speed.sv
module wsmsa_speed (
	input  wsmsa_pkg::speed_t     wheel_fl,
	input  wsmsa_pkg::speed_t     wheel_fr,
	input  wsmsa_pkg::speed_t     wheel_rl,
	input  wsmsa_pkg::speed_t     wheel_rr,
	input  wsmsa_pkg::factor_t    factor,
	output wsmsa_pkg::speed_res_t result
);
	import wsmsa_pkg::*;

	localparam int SUM_W  = SPEED_W + 2;
	localparam int MID_W  = SPEED_W + 1;
	localparam int PROD_W = MID_W + FACTOR_W + 1;
	localparam int RND_W  = PROD_W + 1;
	localparam int Q_W    = RND_W - 15;

	speed_t                    min_a, max_a, min_b, max_b, min_all, max_all;
	logic signed [SUM_W-1:0]   sum_all;
	logic signed [SUM_W-1:0]   mid_wide;
	logic signed [MID_W-1:0]   mid_sum;
	logic signed [FACTOR_W:0]  factor_s;
	logic signed [PROD_W-1:0]  prod;
	logic signed [RND_W-1:0]   rnd;
	logic signed [Q_W-1:0]     q;

	// Smallest and largest of the four speeds; the two middle ones are what is left.
	always_comb begin
		min_a   = (wheel_fl < wheel_fr) ? wheel_fl : wheel_fr;
		max_a   = (wheel_fl < wheel_fr) ? wheel_fr : wheel_fl;
		min_b   = (wheel_rl < wheel_rr) ? wheel_rl : wheel_rr;
		max_b   = (wheel_rl < wheel_rr) ? wheel_rr : wheel_rl;
		min_all = (min_a < min_b) ? min_a : min_b;
		max_all = (max_a < max_b) ? max_b : max_a;
	end

	// Sum of the middle pair.
	assign sum_all  = SUM_W'(wheel_fl) + SUM_W'(wheel_fr) + SUM_W'(wheel_rl)
			+ SUM_W'(wheel_rr);
	assign mid_wide = sum_all - SUM_W'(min_all) - SUM_W'(max_all);
	assign mid_sum  = mid_wide[MID_W-1:0];

	// Scale by the Q2.14 factor, halve and round to nearest.
	assign factor_s = $signed({1'b0, factor});
	assign prod     = PROD_W'(mid_sum * factor_s);
	assign rnd      = RND_W'(prod) + RND_W'(16384);
	assign q        = Q_W'(rnd >>> 15);

	// Clip to the output range and flag it.
	always_comb begin
		if (q > Q_W'(32767)) begin
			result.value     = speed_t'(16'sh7FFF);
			result.saturated = 1'b1;
		end else if (q < -Q_W'(32768)) begin
			result.value     = speed_t'(16'sh8000);
			result.saturated = 1'b1;
		end else begin
			result.value     = q[SPEED_W-1:0];
			result.saturated = 1'b0;
		end
	end

endmodule

FILE: rtl/core/wsmsa_angle.sv
module wsmsa_angle (
	input  wsmsa_pkg::steer_t steer,
	output wsmsa_pkg::fwa_t   fwa
);
	import wsmsa_pkg::*;

	localparam int PROD_W = STEER_W + RECIP_W;
	localparam int RND_W  = PROD_W + 1;

	logic                      neg;
	logic [STEER_W-1:0]        mag_in;
	logic [SEG_IDX_W-1:0]      sel;
	logic [STEER_W-1:0]        diff;
	logic [PROD_W-1:0]         prod;
	logic [RND_W-1:0]          rnd;
	logic [FWA_W-1:0]          mag_out;

	// Absolute steering angle; the most negative input maps to 2^23 without loss.
	assign neg    = steer[STEER_W-1];
	assign mag_in = neg ? STEER_W'(-steer) : STEER_W'(steer);

	// First segment whose upper break point lies above the angle, else the last one.
	always_comb begin
		sel = SEG_IDX_W'(NUM_SEGMENTS - 1);
		for (int k = NUM_SEGMENTS - 1; k >= 0; k--) begin
			if (SEG_LIMIT[k] > mag_in) begin
				sel = SEG_IDX_W'(k);
			end
		end
	end

	// Linear interpolation within the chosen segment, rounded to nearest.
	assign diff    = mag_in - SEG_START[sel];
	assign prod    = PROD_W'(diff) * PROD_W'(SEG_RECIP[sel]);
	assign rnd     = RND_W'(prod) + (RND_W'(1) << (RECIP_SHIFT - 1));
	assign mag_out = SEG_OFFSET[sel] + rnd[RECIP_SHIFT +: FWA_W];

	// Put the sign of the steering angle back.
	assign fwa = neg ? fwa_t'(-mag_out) : fwa_t'(mag_out);

endmodule

FILE: rtl/core/wheel_speed_median_steer_angle_map.sv
// Wheel speed median and steering angle map.
//
// Input channel: in_valid with in_stall carries four wheel speeds and the
// steering-wheel angle; a request is taken at a clock edge where in_valid is
// high and in_stall is low. Output channel: out_valid with out_stall carries
// long_speed, speed_saturated and road_wheel_angle, one result per request.
// The speed scale is written through speed_factor_we and speed_factor_wdata;
// the user must do so while the block is idle; the block does not enforce it.
//
// A request is held in an input register; the median, scaling and segment
// map are computed in one pass and stored in the result register once it is
// free, and the result is offered from there. One request is taken every
// cycle while results are drained; the rate is set by the two-register
// pipeline, which collapses bubbles.
//
// When the receiver stalls, the result register holds and the input register
// fills; in_stall rises only once both are occupied. Reset empties the
// pipeline and loads the speed scale with 1.0.
module wheel_speed_median_steer_angle_map (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      speed_factor_we,
	input  wsmsa_pkg::factor_t        speed_factor_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  wsmsa_pkg::speed_t         wheel_speed_fl,
	input  wsmsa_pkg::speed_t         wheel_speed_fr,
	input  wsmsa_pkg::speed_t         wheel_speed_rl,
	input  wsmsa_pkg::speed_t         wheel_speed_rr,
	input  wsmsa_pkg::steer_t         steering_angle,
	output logic                      out_valid,
	input  logic                      out_stall,
	output wsmsa_pkg::speed_t         long_speed,
	output logic                      speed_saturated,
	output wsmsa_pkg::fwa_t           road_wheel_angle
);
	import wsmsa_pkg::*;

	factor_t    speed_factor_q;
	logic       valid_s1, valid_s2;
	speed_t     wfl_s1, wfr_s1, wrl_s1, wrr_s1;
	steer_t     steer_s1;
	speed_res_t speed_res;
	fwa_t       fwa_calc;
	speed_res_t speed_res_s2;
	fwa_t       fwa_s2;
	logic       adv_s2, adv_s1;

	// Speed scale register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_factor_q <= SPEED_FACTOR_RESET;
		end else if (speed_factor_we) begin
			speed_factor_q <= speed_factor_wdata;
		end
	end

	// Each stage moves on when the one after it is empty or being emptied.
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// Pipeline occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (in_valid && adv_s1) begin
			wfl_s1   <= wheel_speed_fl;
			wfr_s1   <= wheel_speed_fr;
			wrl_s1   <= wheel_speed_rl;
			wrr_s1   <= wheel_speed_rr;
			steer_s1 <= steering_angle;
		end
	end

	// Longitudinal speed path.
	wsmsa_speed u_speed (
		.wheel_fl (wfl_s1),
		.wheel_fr (wfr_s1),
		.wheel_rl (wrl_s1),
		.wheel_rr (wrr_s1),
		.factor   (speed_factor_q),
		.result   (speed_res)
	);

	// Steering map path.
	wsmsa_angle u_angle (
		.steer (steer_s1),
		.fwa   (fwa_calc)
	);

	// Result register.
	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s2) begin
			speed_res_s2 <= speed_res;
			fwa_s2       <= fwa_calc;
		end
	end

	assign out_valid        = valid_s2;
	assign long_speed       = speed_res_s2.value;
	assign speed_saturated  = speed_res_s2.saturated;
	assign road_wheel_angle = fwa_s2;

`ifndef NO_ASSERTIONS
	// The input side only stalls when both registers hold a request.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled while the pipeline has room");

	// A taken request reaches the input register.
	a_take_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted request lost before the input register");

	// A request in the input register moves to the result register when it may.
	a_move_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> valid_s2)
		else $error("request lost between input and result registers");

	// A clipped speed sits on one of the range limits.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && speed_saturated) |->
		(long_speed == speed_t'(16'sh7FFF) || long_speed == speed_t'(16'sh8000)))
		else $error("saturation flag without a clipped speed");
`endif

endmodule

FILE: bench/wheel_speed_median_steer_angle_map_tb.sv
module wheel_speed_median_steer_angle_map_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wsmsa_pkg::*;

	localparam int STALL_LIMIT     = 2000;
	localparam int HOLD_OFF_CYCLES = 48;
	localparam int RANDOM_PHASES   = 6;
	localparam int PHASE_REQUESTS  = 75;
	localparam int MAX_REPORTS     = 10;

	// Steering map, one entry per segment: upper break point, lower break point,
	// wheel angle at the lower break point and slope reciprocal scaled by 2^24.
	localparam int ANGLE_BREAK [NUM_SEGMENTS] = '{
		27652, 49224, 74932, 91452, 118930, 240614,
		355871, 489888, 631788, 774079, 885745, 6553600
	};
	localparam int ANGLE_BASE [NUM_SEGMENTS] = '{
		0, 27652, 49224, 74932, 91452, 118930,
		240614, 355871, 489888, 631788, 774079, 885745
	};
	localparam int ANGLE_OFFSET [NUM_SEGMENTS] = '{
		0, 1144, 2288, 3431, 4575, 5719,
		11438, 17157, 22876, 28595, 34315, 37746
	};
	localparam int ANGLE_RECIP [NUM_SEGMENTS] = '{
		693990, 889566, 746483, 1161576, 698381, 788525,
		832492, 715956, 676182, 674325, 515561, 455748
	};

	typedef struct packed {
		speed_t fl;
		speed_t fr;
		speed_t rl;
		speed_t rr;
		steer_t steer;
	} vehicle_request_t;

	typedef struct packed {
		speed_t speed;
		logic   clipped;
		fwa_t   angle;
	} vehicle_state_t;

	typedef struct {
		factor_t          factor;
		vehicle_request_t request;
		bit               typed;
		vehicle_state_t   state;
	} directed_row_t;

	logic    clk                = 1'b0;
	logic    arst_n             = 1'b0;
	logic    speed_factor_we    = 1'b0;
	factor_t speed_factor_wdata = '0;
	logic    in_valid           = 1'b0;
	logic    in_stall;
	speed_t  wheel_speed_fl     = '0;
	speed_t  wheel_speed_fr     = '0;
	speed_t  wheel_speed_rl     = '0;
	speed_t  wheel_speed_rr     = '0;
	steer_t  steering_angle     = '0;
	logic    out_valid;
	logic    out_stall          = 1'b0;
	speed_t  long_speed;
	logic    speed_saturated;
	fwa_t    road_wheel_angle;

	vehicle_state_t pending_states [$];
	directed_row_t  directed_rows [$];
	factor_t        speed_scale      = SPEED_FACTOR_RESET;
	int             mismatch_count   = 0;
	int             stalled_cycles   = 0;
	bit             steady_run       = 1'b0;
	bit             hold_off_request = 1'b0;

	wheel_speed_median_steer_angle_map u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.speed_factor_we    (speed_factor_we),
		.speed_factor_wdata (speed_factor_wdata),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.wheel_speed_fl     (wheel_speed_fl),
		.wheel_speed_fr     (wheel_speed_fr),
		.wheel_speed_rl     (wheel_speed_rl),
		.wheel_speed_rr     (wheel_speed_rr),
		.steering_angle     (steering_angle),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.long_speed         (long_speed),
		.speed_saturated    (speed_saturated),
		.road_wheel_angle   (road_wheel_angle)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Longitudinal speed from the middle pair of sorted wheel speeds, and the
	// road wheel angle from the segment map of the absolute steering angle.
	function automatic vehicle_state_t predict_vehicle_state(input vehicle_request_t rq,
		input factor_t factor);
		vehicle_state_t st;
		int             w [4];
		int             swap;
		longint         scaled;
		longint         steer_abs;
		longint         slope;
		int             seg;
		longint         mag;

		w[0] = rq.fl;
		w[1] = rq.fr;
		w[2] = rq.rl;
		w[3] = rq.rr;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3 - i; j++) begin
				if (w[j] > w[j + 1]) begin
					swap     = w[j];
					w[j]     = w[j + 1];
					w[j + 1] = swap;
				end
			end
		end

		// Halving and the Q2.14 scale together are a shift by 15, rounded.
		scaled = (longint'(w[1] + w[2]) * longint'(factor) + 64'sd16384) >>> 15;
		st.clipped = 1'b0;
		if (scaled > 32767) begin
			scaled     = 32767;
			st.clipped = 1'b1;
		end else if (scaled < -32768) begin
			scaled     = -32768;
			st.clipped = 1'b1;
		end
		st.speed = speed_t'(scaled);

		// The first segment whose upper break point lies above the angle wins;
		// anything beyond the last break point stays on the last line.
		steer_abs = longint'(rq.steer);
		if (steer_abs < 0)
			steer_abs = -steer_abs;
		seg = NUM_SEGMENTS - 1;
		for (int k = NUM_SEGMENTS - 1; k >= 0; k--) begin
			if (longint'(ANGLE_BREAK[k]) > steer_abs)
				seg = k;
		end
		slope = (steer_abs - ANGLE_BASE[seg]) * longint'(ANGLE_RECIP[seg]);
		mag   = ANGLE_OFFSET[seg] + ((slope + 64'sd8388608) >>> 24);
		st.angle = (rq.steer < 0) ? fwa_t'(-mag) : fwa_t'(mag);
		return st;
	endfunction

	function automatic speed_t edge_speed();
		case ($urandom_range(5))
			0:       return speed_t'(-32768);
			1:       return speed_t'(32767);
			2:       return speed_t'(0);
			3:       return speed_t'(-1);
			4:       return speed_t'(1);
			default: return speed_t'(-32767);
		endcase
	endfunction

	// Random request: a mix of unrelated speeds, four wheels close together as
	// on a real vehicle, edge values and clusters near the rails; angles over
	// the full range, near the break points, in the usual driving range and
	// around the huge-angle region.
	function automatic vehicle_request_t random_request();
		vehicle_request_t rq;
		int               base;
		int               k;
		int               mag;

		case ($urandom_range(3))
			0: begin
				rq.fl = speed_t'($urandom);
				rq.fr = speed_t'($urandom);
				rq.rl = speed_t'($urandom);
				rq.rr = speed_t'($urandom);
			end
			1: begin
				base = int'($urandom_range(65535)) - 32768;
				rq.fl = speed_t'(base + int'($urandom_range(64)) - 32);
				rq.fr = speed_t'(base + int'($urandom_range(64)) - 32);
				rq.rl = speed_t'(base + int'($urandom_range(64)) - 32);
				rq.rr = speed_t'(base + int'($urandom_range(64)) - 32);
			end
			2: begin
				rq.fl = edge_speed();
				rq.fr = edge_speed();
				rq.rl = edge_speed();
				rq.rr = edge_speed();
			end
			default: begin
				if ($urandom_range(1) == 1) begin
					base = 32767 - int'($urandom_range(400));
					rq.fl = speed_t'(base - int'($urandom_range(16)));
					rq.fr = speed_t'(base - int'($urandom_range(16)));
					rq.rl = speed_t'(base - int'($urandom_range(16)));
					rq.rr = speed_t'(base - int'($urandom_range(16)));
				end else begin
					base = -32768 + int'($urandom_range(400));
					rq.fl = speed_t'(base + int'($urandom_range(16)));
					rq.fr = speed_t'(base + int'($urandom_range(16)));
					rq.rl = speed_t'(base + int'($urandom_range(16)));
					rq.rr = speed_t'(base + int'($urandom_range(16)));
				end
			end
		endcase

		case ($urandom_range(3))
			0: mag = int'($urandom_range(8388608));
			1: begin
				k   = int'($urandom_range(NUM_SEGMENTS - 1));
				mag = ANGLE_BREAK[k] + int'($urandom_range(6)) - 3;
			end
			2: mag = int'($urandom_range(140000));
			default: mag = int'($urandom_range(8388608, 6553590));
		endcase
		if ($urandom_range(1) == 1)
			rq.steer = steer_t'(-mag);
		else
			rq.steer = steer_t'(mag);
		return rq;
	endfunction

	task automatic add_row(input factor_t factor, input int fl, input int fr, input int rl,
		input int rr, input int steer, input bit typed, input int speed, input bit clipped,
		input int angle);
		directed_row_t row;

		row.factor        = factor;
		row.request.fl    = speed_t'(fl);
		row.request.fr    = speed_t'(fr);
		row.request.rl    = speed_t'(rl);
		row.request.rr    = speed_t'(rr);
		row.request.steer = steer_t'(steer);
		row.typed         = typed;
		row.state.speed   = speed_t'(speed);
		row.state.clipped = clipped;
		row.state.angle   = fwa_t'(angle);
		directed_rows.push_back(row);
	endtask

	// Offer one request, idling beforehand at random, and log the result it
	// should produce once the block has taken it.
	task automatic offer_request(input vehicle_request_t rq, input bit typed,
		input vehicle_state_t typed_state);
		while (!steady_run && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		wheel_speed_fl <= rq.fl;
		wheel_speed_fr <= rq.fr;
		wheel_speed_rl <= rq.rl;
		wheel_speed_rr <= rq.rr;
		steering_angle <= rq.steer;
		do
			@(posedge clk);
		while (in_stall);
		pending_states.push_back(typed ? typed_state : predict_vehicle_state(rq, speed_scale));
	endtask

	// The sender pauses until every outstanding result has been delivered.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_states.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_speed_factor(input factor_t value);
		speed_factor_we    <= 1'b1;
		speed_factor_wdata <= value;
		@(posedge clk);
		speed_factor_we <= 1'b0;
		speed_scale = value;
	endtask

	// Receiver: random stalls, one long hold-off on request, and a check of
	// every result taken against the oldest outstanding prediction.
	initial begin
		vehicle_state_t want;

		wait (arst_n);
		forever begin
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			out_stall <= !steady_run && ($urandom_range(99) < 14);
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_states.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("unexpected result: long_speed %0d sat %0b angle %0d",
							long_speed, speed_saturated, road_wheel_angle);
				end else begin
					want = pending_states.pop_front();
					if (long_speed !== want.speed || speed_saturated !== want.clipped ||
						road_wheel_angle !== want.angle) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("mismatch: long_speed %0d/%0d sat %0b/%0b angle %0d/%0d (exp/got)",
								want.speed, long_speed, want.clipped, speed_saturated,
								want.angle, road_wheel_angle);
					end
				end
			end
		end
	end

	// Watchdog: the run is stuck if no request and no result moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stalled_cycles <= 0;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
			if (stalled_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		factor_t factor;

		// Directed rows: zero and rail speeds, break points, the huge and the most
		// negative steering angle, full, saturating and zero speed scale.
		add_row(16384, 0, 0, 0, 0, 0, 1, 0, 0, 0);
		add_row(16384, 32767, 32767, 32767, 32767, 0, 1, 32767, 0, 0);
		add_row(16384, -32768, -32768, -32768, -32768, 0, 1, -32768, 0, 0);
		add_row(16384, 100, 200, 300, 400, 27652, 1, 250, 0, 1144);
		add_row(16384, 400, -100, 300, 0, -27652, 1, 150, 0, -1144);
		add_row(16384, 7, 7, 7, 7, 885745, 1, 7, 0, 37746);
		add_row(16384, 1000, 900, 1100, 950, 6553600, 0, 0, 0, 0);
		add_row(16384, -500, 500, -600, 600, 8388607, 0, 0, 0, 0);
		add_row(16384, 12345, -2345, 345, 45, -8388608, 0, 0, 0, 0);
		add_row(16384, 3, 1, 4, 1, 27651, 0, 0, 0, 0);
		add_row(16384, 5, 9, 2, 6, 1, 0, 0, 0, 0);
		add_row(16384, -1, -1, -1, -1, -1, 0, 0, 0, 0);
		add_row(16384, 32767, -32768, 32767, -32768, 24'h555555, 0, 0, 0, 0);
		add_row(65535, 32767, 32767, 32767, 32767, 0, 1, 32767, 1, 0);
		add_row(65535, -32768, -32768, -32768, -32768, 0, 1, -32768, 1, 0);
		add_row(65535, 16384, 16384, 16384, 16384, -6553600, 0, 0, 0, 0);
		add_row(65535, 1, 2, 3, 4, 500000, 0, 0, 0, 0);
		add_row(0, 32767, 32767, 32767, 32767, 0, 1, 0, 0, 0);
		add_row(0, -32768, -32768, -32768, -32768, -8388608, 0, 0, 0, 0);
		add_row(0, 1234, -5678, 910, -1112, 24'h2AAAAA, 0, 0, 0, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].factor != speed_scale) begin
				drain_results();
				write_speed_factor(directed_rows[i].factor);
			end
			offer_request(directed_rows[i].request, directed_rows[i].typed,
				directed_rows[i].state);
		end

		// Random phases, each under its own speed scale; the second runs with no
		// idling on either side and the fourth holds the receiver off for a while.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0:       factor = factor_t'($urandom);
				1:       factor = 16'd16384;
				2:       factor = 16'd65535;
				3:       factor = factor_t'($urandom_range(24576, 8192));
				4:       factor = 16'd1;
				default: factor = factor_t'($urandom);
			endcase
			drain_results();
			write_speed_factor(factor);
			steady_run = (phase == 1);
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				if (phase == 3 && n == 10)
					hold_off_request = 1'b1;
				offer_request(random_request(), 1'b0, '0);
			end
		end
		steady_run = 1'b0;

		drain_results();
		if (mismatch_count == 0 && pending_states.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: wheel_speed_median_steer_angle_map.f
rtl/core/wsmsa_pkg.sv
rtl/core/wsmsa_speed.sv
rtl/core/wsmsa_angle.sv
rtl/core/wheel_speed_median_steer_angle_map.sv
bench/wheel_speed_median_steer_angle_map_tb.sv
